// ----- sv/erle_pkg.sv -----
package erle_pkg;

  localparam int unsigned BLOCK_BYTES = 16384;
  localparam int unsigned BW_W = $clog2(BLOCK_BYTES + 1);
  localparam logic [BW_W-1:0] BLOCK_LIMIT = BW_W'(BLOCK_BYTES);

  localparam logic [7:0] ESC_BYTE = 8'hED;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One decoded input: a primary run, an optional single-copy second run, block end.
  typedef struct packed {
    logic [7:0] value0;
    logic [7:0] count0;
    logic [7:0] value1;
    logic       has_run1;
    logic       last;
  } cmd_t;

endpackage

// ----- sv/erle_front.sv -----
module erle_front
  import erle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       block_last_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC1 = 2'd1;
  localparam logic [1:0] PH_ESC2 = 2'd2;
  localparam logic [1:0] PH_CNT  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] pending_q, pending_d;
  logic       accept;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    cmd_o     = '0;
    cmd_o.last = block_last_i;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == ESC_BYTE && !block_last_i) begin
          phase_d = PH_ESC1;
        end else begin
          cmd_o.value0 = in_byte_i;
          cmd_o.count0 = 8'd1;
        end
      end
      PH_ESC1: begin
        if (in_byte_i == ESC_BYTE) begin
          phase_d = PH_ESC2;
        end else begin
          cmd_o.value0   = ESC_BYTE;
          cmd_o.count0   = 8'd1;
          cmd_o.value1   = in_byte_i;
          cmd_o.has_run1 = 1'b1;
          phase_d        = PH_IDLE;
        end
      end
      PH_ESC2: begin
        pending_d = in_byte_i;
        phase_d   = PH_CNT;
      end
      PH_CNT: begin
        cmd_o.value0 = in_byte_i;
        cmd_o.count0 = pending_q;
        pending_d    = 8'd0;
        phase_d      = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    if (block_last_i) begin
      phase_d   = PH_IDLE;
      pending_d = 8'd0;
    end
  end

  assign push_o = accept && (cmd_o.count0 != 8'd0 || block_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pending_q <= 8'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
    end
  end

endmodule

// ----- sv/erle_cmd_fifo.sv -----
module erle_cmd_fifo
  import erle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t                 entries_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign ready_o = cnt_q != CMD_CNT_W'(CMD_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CMD_CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/erle_back.sv -----
module erle_back
  import erle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] run_value_o,
  output logic [7:0] run_count_o,
  output logic       item_last_o,
  output logic       block_done_o,
  output logic       truncated_o
);

  logic            sub_q;
  logic [BW_W-1:0] written_q;
  logic            clip_q;

  logic            out_valid_q;
  logic [7:0]      value_q, count_q;
  logic            item_last_q, done_q, trunc_q;

  logic [7:0]      cur_v, cur_n, nxt_n, c_cur;
  logic [BW_W-1:0] room, room_n;
  logic            clip_cur, clip_nxt, e_nxt, emit_cur, marker, res_valid, step;

  always_comb begin
    cur_v    = sub_q ? cmd_i.value1 : cmd_i.value0;
    cur_n    = sub_q ? 8'd1 : cmd_i.count0;
    nxt_n    = (!sub_q && cmd_i.has_run1) ? 8'd1 : 8'd0;
    room     = BLOCK_LIMIT - written_q;
    clip_cur = BW_W'(cur_n) > room;
    c_cur    = clip_cur ? room[7:0] : cur_n;
    room_n   = room - BW_W'(c_cur);
    clip_nxt = BW_W'(nxt_n) > room_n;
    e_nxt    = (nxt_n != 8'd0) && (room_n != '0);
    emit_cur = c_cur != 8'd0;
    marker   = !emit_cur && !e_nxt && cmd_i.last;
    res_valid = emit_cur || marker;
    step     = cmd_valid_i && (!res_valid || !out_valid_q || out_ready_i);
  end

  assign cmd_pop_o = step && !e_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q     <= 1'b0;
      written_q <= '0;
      clip_q    <= 1'b0;
    end else if (step) begin
      if (e_nxt) begin
        sub_q     <= 1'b1;
        written_q <= written_q + BW_W'(c_cur);
        clip_q    <= clip_q | clip_cur;
      end else begin
        sub_q <= 1'b0;
        if (cmd_i.last) begin
          written_q <= '0;
          clip_q    <= 1'b0;
        end else begin
          written_q <= written_q + BW_W'(c_cur);
          clip_q    <= clip_q | clip_cur | clip_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      value_q     <= marker ? 8'd0 : cur_v;
      count_q     <= marker ? 8'd0 : c_cur;
      item_last_q <= !e_nxt;
      done_q      <= cmd_i.last && !e_nxt;
      trunc_q     <= marker ? (clip_q | clip_cur | clip_nxt) : (clip_q | clip_cur);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_value_o  = value_q;
  assign run_count_o  = count_q;
  assign item_last_o  = item_last_q;
  assign block_done_o = done_q;
  assign truncated_o  = trunc_q;

endmodule

// ----- sv/escape_rle_byte_decoder_unit.sv -----
// Channel  Handshake                 Payload
// input    in_valid_i / in_ready_o   in_byte_i, block_last_i
// output   out_valid_o / out_ready_i run_value_o, run_count_o, item_last_o,
//                                    block_done_o, truncated_o
//
// One input byte is taken per cycle while the four-entry command queue has room.
// The back end retires one result per cycle while the output is not stalled, so an
// input that yields two results holds it for both in turn; that queue absorbs the difference.
// Results appear in the cycle after the back end handles a command, from a register.
// Reset clears the escape parser, the queue, the block counters and the result valid flag.
// A stalled output fills the queue and then holds in_ready_o low.
module escape_rle_byte_decoder_unit
  import erle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       block_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] run_value_o,
  output logic [7:0] run_count_o,
  output logic       item_last_o,
  output logic       block_done_o,
  output logic       truncated_o
);

  logic push, fifo_ready, fifo_valid, pop;
  cmd_t push_cmd, head_cmd;

  erle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .block_last_i(block_last_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .cmd_ready_i (fifo_ready)
  );

  erle_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .ready_o(fifo_ready),
    .valid_o(fifo_valid),
    .cmd_o  (head_cmd),
    .pop_i  (pop)
  );

  erle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .run_value_o (run_value_o),
    .run_count_o (run_count_o),
    .item_last_o (item_last_o),
    .block_done_o(block_done_o),
    .truncated_o (truncated_o)
  );

endmodule

// ----- sv/erle_checker.sv -----
module erle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       block_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] run_value_o,
  input logic [7:0] run_count_o,
  input logic       item_last_o,
  input logic       block_done_o,
  input logic       truncated_o
);

  // A stalled input transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i) &&
      $stable(block_last_i))
    else $error("input payload changed while stalled");

  // A stalled result transaction keeps its value, count, block end and truncation flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(run_value_o) &&
      $stable(run_count_o) && $stable(block_done_o) && $stable(truncated_o))
    else $error("output payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_done_o |-> item_last_o)
    else $error("block end without item end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_count_o == 8'd0 |-> block_done_o && run_value_o == 8'd0)
    else $error("empty run that is not a block end marker");

  // The truncation flag is sticky until the block ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && truncated_o && !block_done_o ##1 out_valid_o
      |-> truncated_o)
    else $error("truncation flag cleared inside a block");

endmodule

bind escape_rle_byte_decoder_unit erle_checker u_erle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_byte_i   (in_byte_i),
  .block_last_i(block_last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .run_value_o (run_value_o),
  .run_count_o (run_count_o),
  .item_last_o (item_last_o),
  .block_done_o(block_done_o),
  .truncated_o (truncated_o)
);

// ----- sim/escape_rle_byte_decoder_checker.sv -----
`timescale 1ns / 1ps

module escape_rle_byte_decoder_checker
  import erle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       block_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] run_value_i,
  input  logic [7:0] run_count_i,
  input  logic       item_last_i,
  input  logic       block_done_i,
  input  logic       truncated_i,
  output int         fail_count_o,
  output int         expected_left_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SAW_ESC,
    PH_SAW_PAIR,
    PH_SAW_COUNT
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic       item_last;
    logic       block_done;
    logic       truncated;
  } run_t;

  esc_phase_e      phase = PH_IDLE;
  logic [7:0]      pending_copies = '0;
  logic [BW_W-1:0] written = '0;
  logic            clipped = 1'b0;

  run_t batch [2];
  int   batch_len;
  run_t expected_runs [$];
  run_t want;

  // Clips a run to the room left in the block and queues it in the batch if
  // anything remains of it.
  function automatic void issue_run(input logic [7:0] value, input logic [7:0] count);
    logic [BW_W-1:0] room;
    logic [BW_W-1:0] copies;
    room = BLOCK_LIMIT - written;
    copies = BW_W'(count);
    if (copies > room) begin
      copies = room;
      clipped = 1'b1;
    end
    if (copies != '0) begin
      written = written + copies;
      batch[batch_len] = '{value, copies[7:0], 1'b0, 1'b0, clipped};
      batch_len++;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic blast);
    batch_len = 0;
    case (phase)
      PH_IDLE: begin
        if (b == ESC_BYTE && !blast) begin
          phase = PH_SAW_ESC;
        end else begin
          issue_run(b, 8'd1);
        end
      end
      PH_SAW_ESC: begin
        if (b == ESC_BYTE) begin
          phase = PH_SAW_PAIR;
        end else begin
          issue_run(ESC_BYTE, 8'd1);
          issue_run(b, 8'd1);
          phase = PH_IDLE;
        end
      end
      PH_SAW_PAIR: begin
        pending_copies = b;
        phase = PH_SAW_COUNT;
      end
      default: begin
        issue_run(b, pending_copies);
        pending_copies = '0;
        phase = PH_IDLE;
      end
    endcase
    if (blast) begin
      if (batch_len == 0) begin
        batch[0] = '{8'd0, 8'd0, 1'b0, 1'b0, clipped};
        batch_len = 1;
      end
      batch[batch_len-1].block_done = 1'b1;
      phase = PH_IDLE;
      pending_copies = '0;
      written = '0;
      clipped = 1'b0;
    end
    if (batch_len > 0) begin
      batch[batch_len-1].item_last = 1'b1;
    end
    for (int i = 0; i < batch_len; i++) begin
      expected_runs.push_back(batch[i]);
    end
  endfunction

  function automatic void check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s expected %0d got %0d", name, expected, actual);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_byte_i, block_last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected transaction: run_value %0d run_count %0d",
                 run_value_i, run_count_i);
          fail_count_o++;
        end else begin
          want = expected_runs.pop_front();
          check_field("run_value", want.value, run_value_i);
          check_field("run_count", want.count, run_count_i);
          check_field("item_last", want.item_last, item_last_i);
          check_field("block_done", want.block_done, block_done_i);
          check_field("truncated", want.truncated, truncated_i);
        end
      end
    end
    expected_left_o <= expected_runs.size();
  end

endmodule

// ----- sim/escape_rle_byte_decoder_unit_test.sv -----
`timescale 1ns / 1ps

module escape_rle_byte_decoder_unit_test;
  import erle_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1500;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       block_last_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] run_value_o;
  logic [7:0] run_count_o;
  logic       item_last_o;
  logic       block_done_o;
  logic       truncated_o;

  int         fail_count;
  int         expected_left;
  int         cycles = 0;
  int         items_sent = 0;
  int         block_no;
  logic       calm = 1'b0;
  logic [7:0] block_buf [$];

  escape_rle_byte_decoder_unit DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .block_last_i,
    .out_valid_o,
    .out_ready_i,
    .run_value_o,
    .run_count_o,
    .item_last_o,
    .block_done_o,
    .truncated_o
  );

  escape_rle_byte_decoder_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .in_byte_i,
    .block_last_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .run_value_i     (run_value_o),
    .run_count_i     (run_count_o),
    .item_last_i     (item_last_o),
    .block_done_i    (block_done_o),
    .truncated_i     (truncated_o),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 9);
  end

  task automatic send_byte(input logic [7:0] b, input logic blast);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    block_last_i <= blast;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_block();
    for (int i = 0; i < block_buf.size(); i++) begin
      send_byte(block_buf[i], i == block_buf.size() - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(254));
    if (b >= ESC_BYTE) b++;
    return b;
  endfunction

  function automatic void push_escape(input logic [7:0] copies);
    block_buf.push_back(ESC_BYTE);
    block_buf.push_back(ESC_BYTE);
    block_buf.push_back(copies);
    block_buf.push_back(8'($urandom_range(255)));
  endfunction

  // A heavy block is mostly long runs, so its output overflows the block size.
  function automatic void build_block(input logic heavy);
    int tokens;
    int r;
    block_buf.delete();
    tokens = heavy ? $urandom_range(95, 110) : $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(99);
      if (heavy) begin
        if (r < 80) begin
          push_escape(8'($urandom_range(220, 255)));
        end else if (r < 85) begin
          push_escape(8'd0);
        end else if (r < 92) begin
          block_buf.push_back(ESC_BYTE);
          block_buf.push_back(plain_byte());
        end else begin
          block_buf.push_back(8'($urandom_range(255)));
        end
      end else if (r < 30) begin
        block_buf.push_back(8'($urandom_range(255)));
      end else if (r < 60) begin
        case ($urandom_range(9))
          0: push_escape(8'd0);
          1: push_escape(8'd255);
          2: push_escape(8'd1);
          default: push_escape(8'($urandom_range(255)));
        endcase
      end else if (r < 75) begin
        block_buf.push_back(ESC_BYTE);
        block_buf.push_back(plain_byte());
      end else begin
        for (int n = $urandom_range(1, 3); n > 0; n--) begin
          block_buf.push_back($urandom_range(1) ? ESC_BYTE : 8'($urandom_range(255)));
        end
      end
    end
    case ($urandom_range(7))
      0: block_buf.push_back(ESC_BYTE);
      1: begin
        block_buf.push_back(ESC_BYTE);
        block_buf.push_back(ESC_BYTE);
      end
      2: begin
        block_buf.push_back(ESC_BYTE);
        block_buf.push_back(ESC_BYTE);
        block_buf.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    if (block_buf.size() == 0) begin
      block_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = '0;
    block_last_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    block_buf = {8'h00};
    send_block();
    block_buf = {8'hFF, ESC_BYTE, ESC_BYTE, 8'hFF, 8'h00, ESC_BYTE, ESC_BYTE, ESC_BYTE, 8'hAA,
                 ESC_BYTE, 8'h12, ESC_BYTE};
    send_block();
    block_buf = {ESC_BYTE, ESC_BYTE};
    send_block();
    block_buf = {ESC_BYTE, ESC_BYTE, 8'h07};
    send_block();
    block_buf = {ESC_BYTE, ESC_BYTE, 8'h00, ESC_BYTE};
    send_block();
    wait_for_results();

    block_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm <= (items_sent >= 700 && items_sent < 1000);
      build_block(block_no == 2 || block_no == 25);
      send_block();
      if (block_no == 12) begin
        wait_for_results();
      end
      block_no++;
    end
    calm <= 1'b0;

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
